// ===== rtl/core/kpd_pkg.sv =====
// shared types, constants and the hex to seven-segment table for the keypad display block
`default_nettype none
package kpd_pkg;

    localparam int unsigned NUM_KEYS  = 16;
    localparam int unsigned KEY_W     = 5;
    localparam int unsigned HEX_W     = 4;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned EN_W      = 4;
    localparam int unsigned POSF_W    = 2;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_DAT_W  = 16;
    localparam int unsigned OUT_DAT_W = 24;

    localparam logic [KEY_W-1:0]  NO_KEY        = 5'd16;
    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLDOFF_TICKS = 8'd0,
        CFG_COMMON_ANODE  = 8'd1
    } t_cfg_index;

    // result of one tick as seen from the digit state
    typedef struct packed {
        logic             accepted;
        logic [HEX_W-1:0] digit;
        logic [2:0]       pos;
    } t_step_info;

    // segments a..g in bits 0..6, active high
    function automatic logic [SEG_W-1:0] hex_to_seg(input logic [HEX_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0: s = 7'h3F;
            4'h1: s = 7'h06;
            4'h2: s = 7'h5B;
            4'h3: s = 7'h4F;
            4'h4: s = 7'h66;
            4'h5: s = 7'h6D;
            4'h6: s = 7'h7D;
            4'h7: s = 7'h07;
            4'h8: s = 7'h7F;
            4'h9: s = 7'h6F;
            4'hA: s = 7'h77;
            4'hB: s = 7'h7C;
            4'hC: s = 7'h39;
            4'hD: s = 7'h5E;
            4'hE: s = 7'h79;
            4'hF: s = 7'h71;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kpd_key_encoder.sv =====
// priority encoder: lowest pressed key of the 4x4 pad wins
`default_nettype none
module kpd_key_encoder (
    input  wire logic [kpd_pkg::NUM_KEYS-1:0] i_keys,
    output logic      [kpd_pkg::KEY_W-1:0]    o_key_code
);
    import kpd_pkg::*;

    always_comb begin
        o_key_code = NO_KEY;
        // walk down so the lowest index is written last
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (i_keys[i]) begin
                o_key_code = KEY_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/kpd_digit_state.sv =====
// digit shift register, holdoff counter and scan position
`default_nettype none
module kpd_digit_state #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [kpd_pkg::KEY_W-1:0]  i_key_code,
    input  wire logic [kpd_pkg::HOLD_W-1:0] i_holdoff_ticks,
    output kpd_pkg::t_step_info             o_info
);
    import kpd_pkg::*;

    localparam int unsigned POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [HEX_W-1:0]  r_digits [NUM_DIGITS];
    logic [HEX_W-1:0]  n_digits [NUM_DIGITS];
    logic [HOLD_W-1:0] r_holdoff, n_holdoff;
    logic [POS_W-1:0]  r_scan, n_scan;
    logic              w_take;
    logic [HOLD_W-1:0] w_hold_mid;

    assign w_take = (i_key_code != NO_KEY) && (r_holdoff == '0);

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_digits[i] = r_digits[i];
        end
        if (w_take) begin
            for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                n_digits[i] = r_digits[i+1];
            end
            n_digits[NUM_DIGITS-1] = i_key_code[HEX_W-1:0];
        end
        w_hold_mid = w_take ? i_holdoff_ticks : r_holdoff;
        n_holdoff  = (w_hold_mid != '0) ? w_hold_mid - 1'b1 : w_hold_mid;
        n_scan     = (r_scan == POS_W'(NUM_DIGITS - 1)) ? '0 : r_scan + 1'b1;
    end

    // shown digit comes from the digits after this tick's update
    assign o_info.accepted = w_take;
    assign o_info.digit    = n_digits[r_scan];
    assign o_info.pos      = 3'(r_scan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= '0;
            end
            r_holdoff <= '0;
            r_scan    <= '0;
        end else if (i_step) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= n_digits[i];
            end
            r_holdoff <= n_holdoff;
            r_scan    <= n_scan;
        end
    end

    a_holdoff_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff != '0) |-> !w_take)
        else $error("key taken while holdoff running");

    a_holdoff_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_take && i_holdoff_ticks != '0) |=> (r_holdoff == $past(i_holdoff_ticks) - 1'b1))
        else $error("holdoff not reloaded after accepted key");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_scan != POS_W'(NUM_DIGITS - 1)) |=> (r_scan == $past(r_scan) + 1'b1))
        else $error("scan position did not advance");

    a_new_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_take) |=> (r_digits[NUM_DIGITS-1] == $past(i_key_code[HEX_W-1:0])))
        else $error("accepted key missing from rightmost digit");

endmodule
`default_nettype wire

// ===== rtl/core/keypad_hex_display_controller.sv =====
// top level: keypad tick stream in, multiplexed seven-segment drive stream out
//
// usage: each request on the s_axis channel is one keypad sample tick, tdata[15:0] holds
// the 16 key levels (bit r*4+c). every tick gives exactly one result on m_axis with the
// segment levels, digit enables, shown position, winning key code and an accepted flag.
// the result is registered and valid after the edge that accepts the tick. throughput
// is one tick per cycle while m_axis_tready is high, set by the single output register;
// s_axis_tready stays high as long as the output register is empty or is being taken in
// the same cycle, so a stalled receiver holds its result and backpressures the next tick.
// the config channel writes holdoff_ticks (index 0) and common_anode (index 1), one
// write per cycle, always ready; other indexes are dropped. write it only while idle.
// reset (i_rst_n low, synchronous) clears the digits to zero, the holdoff counter and
// scan position to zero, holdoff_ticks to 100, common_anode to 0, and empties the
// output register.
`default_nettype none
module keypad_hex_display_controller #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] key_pressed
    input  wire logic [kpd_pkg::IN_DAT_W-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [6:0] segments, [10:7] digit_enables, [12:11] digit_position,
    // [17:13] key_code, [18] key_accepted, [23:19] zero
    output logic      [kpd_pkg::OUT_DAT_W-1:0] m_axis_tdata,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kpd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import kpd_pkg::*;

    logic [HOLD_W-1:0]    r_holdoff_ticks;
    logic                 r_common_anode;
    logic                 r_out_valid;
    logic [OUT_DAT_W-1:0] r_out_data, n_out_data;
    logic                 w_step;
    logic [KEY_W-1:0]     w_key_code;
    t_step_info           w_info;
    logic [SEG_W-1:0]     w_seg;
    logic [EN_W-1:0]      w_en;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    kpd_key_encoder u_enc (
        .i_keys     (s_axis_tdata[NUM_KEYS-1:0]),
        .o_key_code (w_key_code)
    );

    kpd_digit_state #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_state (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_key_code      (w_key_code),
        .i_holdoff_ticks (r_holdoff_ticks),
        .o_info          (w_info)
    );

    always_comb begin
        w_seg = hex_to_seg(w_info.digit);
        // positions past the fourth have no enable pin
        w_en  = (w_info.pos < 3'd4) ? (EN_W'(1) << w_info.pos[1:0]) : '0;
        if (r_common_anode) begin
            w_seg = ~w_seg;
        end else begin
            w_en = ~w_en;
        end
        n_out_data = {5'd0, w_info.accepted, w_key_code, w_info.pos[1:0], w_en, w_seg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_ticks <= HOLDOFF_RESET;
            r_common_anode  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOLDOFF_TICKS: r_holdoff_ticks <= i_cfg_data;
                CFG_COMMON_ANODE:  r_common_anode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= n_out_data;
        end
    end

    a_accept_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[18]) |-> (r_out_data[17:13] != NO_KEY))
        else $error("accepted flag without a key");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_one_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[12:11] == 2'(NUM_DIGITS - 1) && NUM_DIGITS <= 4)
            |-> $onehot(r_common_anode ? r_out_data[10:7] : ~r_out_data[10:7]))
        else $error("digit enables not one-hot");

endmodule
`default_nettype wire
